// File: hdl/ppu_pkg.sv
`timescale 1ns / 1ps

package ppu_pkg;

  // Field widths
  localparam int COORD_W = 16;
  localparam int LIFE_W  = 16;
  localparam int SCALE_W = 16;
  localparam int PAIR_W  = 2 * SCALE_W;

  // Command codes
  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef logic [2:0][COORD_W-1:0] vec3_t;

  // One stored particle; element 0 of each vector is x
  typedef struct packed {
    vec3_t             pos;
    vec3_t             vel;
    vec3_t             acc;
    logic [PAIR_W-1:0] scale_pair;
    logic [LIFE_W-1:0] life;
    logic [LIFE_W-1:0] age;
  } ppu_rec_t;

  // Signed Q8.8 add, clamped to the 16-bit range
  function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    logic [COORD_W:0] sum;
    sum = {a[COORD_W-1], a} + {b[COORD_W-1], b};
    if (sum[COORD_W] != sum[COORD_W-1]) begin
      sat_add = sum[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      sat_add = sum[COORD_W-1:0];
    end
  endfunction

endpackage

// File: hdl/ppu_in_if.sv
`timescale 1ns / 1ps

interface ppu_in_if;
  import ppu_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [LIFE_W-1:0]         life;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic signed [COORD_W-1:0] vel_x;
  logic signed [COORD_W-1:0] vel_y;
  logic signed [COORD_W-1:0] vel_z;
  logic signed [COORD_W-1:0] acc_x;
  logic signed [COORD_W-1:0] acc_y;
  logic signed [COORD_W-1:0] acc_z;
  logic [PAIR_W-1:0]         scale_pair;

  modport source (
    output valid, command, life, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
           acc_x, acc_y, acc_z, scale_pair,
    input  ready
  );

  modport sink (
    input  valid, command, life, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
           acc_x, acc_y, acc_z, scale_pair,
    output ready
  );
endinterface

// File: hdl/ppu_out_if.sv
`timescale 1ns / 1ps

interface ppu_out_if;
  import ppu_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic [SCALE_W-1:0]        out_scale;
  logic                      last;

  modport source (
    output valid, out_x, out_y, out_z, out_scale, last,
    input  ready
  );

  modport sink (
    input  valid, out_x, out_y, out_z, out_scale, last,
    output ready
  );
endinterface

// File: hdl/ppu_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
// The caller guarantees the quotient fits in LIFE_W bits (dividend high half
// below the divisor).
module ppu_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [2*ppu_pkg::LIFE_W-1:0] dividend,
  input  logic [ppu_pkg::LIFE_W-1:0]   divisor,
  output logic                         done,
  output logic [ppu_pkg::LIFE_W-1:0]   quotient
);
  import ppu_pkg::*;

  localparam int STEP_W = $clog2(LIFE_W + 1);

  logic [STEP_W-1:0] step_r;
  logic              done_r;
  logic [LIFE_W-1:0] rem_r;
  logic [LIFE_W-1:0] quo_r;

  logic [LIFE_W:0]   trial;
  logic              fits;
  logic [LIFE_W:0]   diff;

  // Shift in the next dividend bit and try a subtract
  assign trial = {rem_r, quo_r[LIFE_W-1]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= (step_r == STEP_W'(1));
      if (start) begin
        step_r <= STEP_W'(LIFE_W);
      end else if (step_r != '0) begin
        step_r <= step_r - STEP_W'(1);
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[2*LIFE_W-1:LIFE_W];
      quo_r <= dividend[LIFE_W-1:0];
    end else if (step_r != '0) begin
      rem_r <= fits ? diff[LIFE_W-1:0] : trial[LIFE_W-1:0];
      quo_r <= {quo_r[LIFE_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: hdl/particle_pool_update.sv
`timescale 1ns / 1ps

// Particle pool with per-tick Euler update.
// in_ch carries commands. An add beat stores one particle as the newest and
// produces nothing; an add to a full pool is dropped. A tick beat first
// sweeps the stored particles, oldest first, dropping those whose age has
// reached their lifetime, then updates each survivor, newest first, and
// sends one vertex beat on out_ch per survivor, with last set on the final
// one. Each survivor takes a memory read, six saturating adds through one
// shared adder, a multiply, and a pass through the bit-serial divider that
// forms the scale, which sets the pace. in_ch is not ready while a tick
// runs. A tick on an empty pool finishes at once with no beat.
// Vertices leave through an output register; if out_ch stalls, the block
// holds the next vertex until the register frees. After the final vertex the
// block takes new commands while that vertex still waits.
// Reset (synchronous, rst_n low) empties the pool; particle storage is not
// cleared, as only stored entries are ever read.
module particle_pool_update #(
  parameter int POOL_SIZE = 64
) (
  input logic      clk,
  input logic      rst_n,
  ppu_in_if.sink   in_ch,
  ppu_out_if.source out_ch
);
  import ppu_pkg::*;

  localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CNT_W = $clog2(POOL_SIZE + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXP_RD,
    S_EXP_CHK,
    S_UPD_RD,
    S_UPD_LD,
    S_UPD_ADD,
    S_UPD_MUL,
    S_DIV,
    S_UPD_WB
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   keep_r, keep_nxt;
  logic [2:0]         step_r, step_nxt;
  ppu_rec_t           work_r, work_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [COORD_W-1:0] out_x_r, out_x_nxt;
  logic [COORD_W-1:0] out_y_r, out_y_nxt;
  logic [COORD_W-1:0] out_z_r, out_z_nxt;
  logic [SCALE_W-1:0] out_scale_r, out_scale_nxt;
  logic               out_last_r, out_last_nxt;

  // Particle store
  ppu_rec_t           mem_r [POOL_SIZE];
  ppu_rec_t           rd_q_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  ppu_rec_t           mem_wdata;
  logic [IDX_W-1:0]   rd_addr;

  // Shared adder and scale datapath
  logic [1:0]         comp;
  logic               vel_step;
  logic [COORD_W-1:0] add_a, add_b, add_y;
  logic [SCALE_W-1:0] scl_start, scl_end, scl_diff, scl_val;
  logic               scl_up;
  logic               div_start, div_done;
  logic [2*LIFE_W-1:0] div_dividend;
  logic [LIFE_W-1:0]  div_q;

  ppu_rec_t           new_rec;
  logic               keep;
  logic [CNT_W-1:0]   keep_inc;

  // Record built from an add beat
  always_comb begin
    new_rec.pos        = {in_ch.pos_z, in_ch.pos_y, in_ch.pos_x};
    new_rec.vel        = {in_ch.vel_z, in_ch.vel_y, in_ch.vel_x};
    new_rec.acc        = {in_ch.acc_z, in_ch.acc_y, in_ch.acc_x};
    new_rec.scale_pair = in_ch.scale_pair;
    new_rec.life       = in_ch.life;
    new_rec.age        = '0;
  end

  // Even steps: vel += acc; odd steps: pos += vel, per component
  assign comp     = step_r[2:1];
  assign vel_step = ~step_r[0];
  assign add_a    = vel_step ? work_r.vel[comp] : work_r.pos[comp];
  assign add_b    = vel_step ? work_r.acc[comp] : work_r.vel[comp];
  assign add_y    = sat_add(add_a, add_b);

  // Scale = start +/- |end - start| * age / life
  assign scl_start    = work_r.scale_pair[PAIR_W-1:SCALE_W];
  assign scl_end      = work_r.scale_pair[SCALE_W-1:0];
  assign scl_up       = scl_end >= scl_start;
  assign scl_diff     = scl_up ? (scl_end - scl_start) : (scl_start - scl_end);
  assign div_dividend = (2*LIFE_W)'(scl_diff) * (2*LIFE_W)'(work_r.age);
  assign scl_val      = scl_up ? (scl_start + div_q) : (scl_start - div_q);

  assign keep     = rd_q_r.age < rd_q_r.life;
  assign keep_inc = keep_r + CNT_W'(keep);

  ppu_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (work_r.life),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_ch.ready = (state_r == S_IDLE);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    keep_nxt      = keep_r;
    step_nxt      = step_r;
    work_nxt      = work_r;
    out_valid_nxt = out_valid_r & ~out_ch.ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_z_nxt     = out_z_r;
    out_scale_nxt = out_scale_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r[IDX_W-1:0];
    mem_wdata     = work_r;
    rd_addr       = idx_r[IDX_W-1:0];
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.command == CMD_ADD) begin
            if (cnt_r < CNT_W'(POOL_SIZE)) begin
              mem_we    = 1'b1;
              mem_waddr = cnt_r[IDX_W-1:0];
              mem_wdata = new_rec;
              cnt_nxt   = cnt_r + CNT_W'(1);
            end
          end else if (cnt_r != '0) begin
            idx_nxt   = '0;
            keep_nxt  = '0;
            state_nxt = S_EXP_RD;
          end
        end
      end

      S_EXP_RD: begin
        state_nxt = S_EXP_CHK;
      end

      // Compact survivors towards the bottom, keeping their order
      S_EXP_CHK: begin
        if (keep) begin
          mem_we    = 1'b1;
          mem_waddr = keep_r[IDX_W-1:0];
          mem_wdata = rd_q_r;
        end
        keep_nxt = keep_inc;
        if (idx_r == cnt_r - CNT_W'(1)) begin
          cnt_nxt = keep_inc;
          if (keep_inc == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = keep_inc - CNT_W'(1);
            state_nxt = S_UPD_RD;
          end
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_EXP_RD;
        end
      end

      S_UPD_RD: begin
        state_nxt = S_UPD_LD;
      end

      S_UPD_LD: begin
        work_nxt     = rd_q_r;
        work_nxt.age = rd_q_r.age + LIFE_W'(1);
        step_nxt     = '0;
        state_nxt    = S_UPD_ADD;
      end

      S_UPD_ADD: begin
        if (vel_step) begin
          work_nxt.vel[comp] = add_y;
        end else begin
          work_nxt.pos[comp] = add_y;
        end
        step_nxt = step_r + 3'd1;
        if (step_r == 3'd5) begin
          state_nxt = S_UPD_MUL;
        end
      end

      S_UPD_MUL: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end

      S_DIV: begin
        if (div_done) begin
          state_nxt = S_UPD_WB;
        end
      end

      // Write back and hand the vertex to the output register
      S_UPD_WB: begin
        if (!out_valid_r || out_ch.ready) begin
          mem_we        = 1'b1;
          out_valid_nxt = 1'b1;
          out_x_nxt     = work_r.pos[0];
          out_y_nxt     = work_r.pos[1];
          out_z_nxt     = work_r.pos[2];
          out_scale_nxt = scl_val;
          out_last_nxt  = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r - CNT_W'(1);
            state_nxt = S_UPD_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    keep_r      <= keep_nxt;
    step_r      <= step_nxt;
    work_r      <= work_nxt;
    out_x_r     <= out_x_nxt;
    out_y_r     <= out_y_nxt;
    out_z_r     <= out_z_nxt;
    out_scale_r <= out_scale_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Particle store: one write port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    rd_q_r <= mem_r[rd_addr];
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_x     = out_x_r;
  assign out_ch.out_y     = out_y_r;
  assign out_ch.out_z     = out_z_r;
  assign out_ch.out_scale = out_scale_r;
  assign out_ch.last      = out_last_r;

endmodule
